// ===== rtl/bfwm_pkg.sv =====
// shared constants and codes for the bounded fifo window mean block
`timescale 1ns / 1ps
`default_nettype none
package bfwm_pkg;

	localparam int DEPTH      = 5;
	localparam int VALUE_BITS = 12;

	// fixed field widths at the ports
	localparam int YEAR_W = 12;
	localparam int OCC_W  = 3;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W = VALUE_BITS + CNT_W;
	// numerator 2*sum+count and denominator 2*count
	localparam int NUM_W = SUM_W + 1;
	localparam int DEN_W = CNT_W + 1;

	// widening widths used to resize between storage and ports
	localparam int VW = (VALUE_BITS > YEAR_W) ? VALUE_BITS : YEAR_W;
	localparam int CW = (CNT_W > OCC_W) ? CNT_W : OCC_W;
	localparam int MW = (NUM_W > YEAR_W) ? NUM_W : YEAR_W;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/bounded_fifo_window_mean.sv =====
// bounded fifo of year values with a running sum and rounded mean
// usage:
//   raise start with action and year_in while busy is low; the command is
//   taken at that edge and busy stays high until the result is shown.
//   action insert appends year_in, first evicting the oldest entry when the
//   queue is full; action remove pops the oldest entry.
//   the result (status, out_valid, year_out, mean_year, occupancy) is held
//   for exactly one cycle while done is high; there is no back pressure.
// sequencing:
//   a command steps through the update, prep and divide states to the done
//   state; the divide state waits on the restoring divider that
//   forms floor((2*sum+count)/(2*count)) one quotient bit per cycle.
//   an empty queue skips the divider and goes from prep straight to done.
//   busy drops after the done cycle, so a new command may be taken right then.
// reset:
//   arst_n clears pointers, count, sum and the sequencer; the queue is empty.
`timescale 1ns / 1ps
`default_nettype none
module bounded_fifo_window_mean (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        action,
	input  wire logic [bfwm_pkg::YEAR_W-1:0] year_in,
	output logic                             done,
	output logic                             status,
	output logic                             out_valid,
	output logic      [bfwm_pkg::YEAR_W-1:0] year_out,
	output logic      [bfwm_pkg::YEAR_W-1:0] mean_year,
	output logic      [bfwm_pkg::OCC_W-1:0]  occupancy
);
	import bfwm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_UPD  = 5'b00010,
		ST_PREP = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	state_t state_q;

	logic [VALUE_BITS-1:0] store_q [DEPTH];
	logic [IDX_W-1:0]      head_q;
	logic [IDX_W-1:0]      tail_q;
	logic [CNT_W-1:0]      count_q;
	logic [SUM_W-1:0]      sum_q;

	logic                  action_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] head_val_q;

	logic                  status_q;
	logic                  out_valid_q;
	logic [YEAR_W-1:0]     year_out_q;
	logic [YEAR_W-1:0]     mean_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  do_pop;
	logic                  do_push;
	logic [SUM_W-1:0]      pop_amt;
	logic [SUM_W-1:0]      push_amt;
	logic [IDX_W-1:0]      head_nxt;
	logic [IDX_W-1:0]      tail_nxt;
	logic [VW-1:0]         year_in_wide;
	logic [VW-1:0]         head_val_wide;
	logic [CW-1:0]         count_wide;
	logic [MW-1:0]         quot_wide;

	logic                  div_go;
	logic                  div_done;
	logic [NUM_W-1:0]      div_num;
	logic [DEN_W-1:0]      div_den;
	logic [NUM_W-1:0]      div_quot;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign empty  = (count_q == '0);

	assign year_in_wide  = VW'(year_in);
	assign head_val_wide = VW'(head_val_q);
	assign count_wide    = CW'(count_q);
	assign quot_wide     = MW'(div_quot);

	// pop on remove of a non-empty queue or on insert into a full one
	assign do_push  = (action_q == ACT_INSERT);
	assign do_pop   = do_push ? full : !empty;
	assign pop_amt  = do_pop ? SUM_W'(head_val_q) : '0;
	assign push_amt = do_push ? SUM_W'(value_q) : '0;
	assign head_nxt = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;

	assign div_go  = (state_q == ST_PREP) && !empty;
	assign div_num = {sum_q, 1'b0} + NUM_W'(count_q);
	assign div_den = {count_q, 1'b0};

	bfwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					sum_q <= sum_q - pop_amt + push_amt;
					if (do_pop) begin
						head_q <= head_nxt;
					end
					if (do_push) begin
						tail_q <= tail_nxt;
					end
					if (do_push && !do_pop) begin
						count_q <= count_q + 1'b1;
					end else if (do_pop && !do_push) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= empty ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers and entry storage
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q   <= action;
			value_q    <= year_in_wide[VALUE_BITS-1:0];
			head_val_q <= store_q[head_q];
		end
		if (state_q == ST_UPD) begin
			if (do_push) begin
				store_q[tail_q] <= value_q;
			end
			status_q    <= (!do_push && empty) ? STATUS_EMPTY : STATUS_OK;
			out_valid_q <= do_pop;
			year_out_q  <= do_pop ? head_val_wide[YEAR_W-1:0] : '0;
		end
		if (state_q == ST_PREP && empty) begin
			mean_q <= '0;
		end else if (state_q == ST_DIV && div_done) begin
			mean_q <= quot_wide[YEAR_W-1:0];
		end
	end

	assign done      = (state_q == ST_DONE);
	assign status    = status_q;
	assign out_valid = out_valid_q;
	assign year_out  = year_out_q;
	assign mean_year = mean_q;
	assign occupancy = count_wide[OCC_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/bfwm_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bfwm_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       go,
	input  wire logic [bfwm_pkg::NUM_W-1:0] num,
	input  wire logic [bfwm_pkg::DEN_W-1:0] den,
	output logic                            done,
	output logic      [bfwm_pkg::NUM_W-1:0] quot
);
	import bfwm_pkg::*;

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic              run_q;
	logic [ITER_W-1:0] iter_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W:0]    trial;
	logic              qbit;
	logic [DEN_W-1:0]  diff;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign qbit  = (trial >= {1'b0, den_q});
	// the difference is below den when qbit is set, so the low bits suffice
	assign diff  = trial[DEN_W-1:0] - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			iter_q <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q  <= 1'b1;
				iter_q <= ITER_W'(NUM_W);
			end else if (run_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift into the numerator register as it empties
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			rem_q <= qbit ? diff : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
		end
	end

	assign quot = num_q;

endmodule
`default_nettype wire

// ===== rtl/bfwm_chk.sv =====
// port-level checks for the bounded fifo window mean block
`timescale 1ns / 1ps
`default_nettype none
module bfwm_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        done,
	input wire logic                        status,
	input wire logic                        out_valid,
	input wire logic [bfwm_pkg::YEAR_W-1:0] year_out,
	input wire logic [bfwm_pkg::YEAR_W-1:0] mean_year,
	input wire logic [bfwm_pkg::OCC_W-1:0]  occupancy
);
	import bfwm_pkg::*;

	// an accepted transaction keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low after accepted transaction");

	// a result is only shown while the command is still in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	// the result strobe lasts a single cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// remove on empty reports nothing and an empty queue
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_EMPTY) |->
			!out_valid && (occupancy == '0) && (mean_year == '0) && (year_out == '0))
		else $error("inconsistent empty-queue result");

endmodule

bind bounded_fifo_window_mean bfwm_chk u_bfwm_chk (.*);
`default_nettype wire

// ===== tb/bfwm_checker.sv =====
// scoreboard for the bounded fifo window mean block: predicts each command's result and compares
`timescale 1ns / 1ps
module bfwm_checker
	import bfwm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              action,
	input  wire logic [YEAR_W-1:0] year_in,
	input  wire logic              done,
	input  wire logic              status,
	input  wire logic              out_valid,
	input  wire logic [YEAR_W-1:0] year_out,
	input  wire logic [YEAR_W-1:0] mean_year,
	input  wire logic [OCC_W-1:0]  occupancy,
	output int                     fail_count,
	output int                     pending,
	output int                     checked,
	output int                     evictions,
	output int                     empty_pops
);

	typedef struct packed {
		logic              status;
		logic              out_valid;
		logic [YEAR_W-1:0] year_out;
		logic [YEAR_W-1:0] mean_year;
		logic [OCC_W-1:0]  occupancy;
	} window_result_t;

	// shadow copy of the queue
	logic [VALUE_BITS-1:0] slots [DEPTH];
	int head_slot;
	int tail_slot;
	int held;
	int slot_sum;

	window_result_t expected_q[$];

	function automatic logic [VALUE_BITS-1:0] pop_oldest();
		logic [VALUE_BITS-1:0] v;
		v = slots[head_slot];
		head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
		held--;
		slot_sum -= v;
		return v;
	endfunction

	function automatic window_result_t apply_command(input logic act,
			input logic [YEAR_W-1:0] yr);
		window_result_t r;
		r = '0;
		r.status = STATUS_OK;
		if (act == ACT_INSERT) begin
			// a full queue drops its oldest entry before taking the new one
			if (held >= DEPTH) begin
				r.year_out = YEAR_W'(pop_oldest());
				r.out_valid = 1'b1;
			end
			slots[tail_slot] = VALUE_BITS'(yr);
			tail_slot = (tail_slot + 1 >= DEPTH) ? 0 : tail_slot + 1;
			held++;
			slot_sum += int'(VALUE_BITS'(yr));
		end else if (held == 0) begin
			r.status = STATUS_EMPTY;
		end else begin
			r.year_out = YEAR_W'(pop_oldest());
			r.out_valid = 1'b1;
		end
		// round half up, empty queue reads as zero
		if (held != 0)
			r.mean_year = YEAR_W'((2 * slot_sum + held) / (2 * held));
		r.occupancy = OCC_W'(held);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		window_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				slots[i] = '0;
			head_slot = 0;
			tail_slot = 0;
			held = 0;
			slot_sum = 0;
			expected_q.delete();
			fail_count = 0;
			checked = 0;
			evictions = 0;
			empty_pops = 0;
		end else begin
			// compare before taking a new transaction so an edge carrying both stays ordered
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no command outstanding");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					compare_field("status", want.status, status);
					compare_field("out_valid", want.out_valid, out_valid);
					compare_field("year_out", want.year_out, year_out);
					compare_field("mean_year", want.mean_year, mean_year);
					compare_field("occupancy", want.occupancy, occupancy);
					checked++;
				end
			end
			if (start && !busy) begin
				want = apply_command(action, year_in);
				if (action == ACT_INSERT && want.out_valid)
					evictions++;
				if (want.status == STATUS_EMPTY)
					empty_pops++;
				expected_q.push_back(want);
			end
		end
		pending = expected_q.size();
	end

endmodule

// ===== tb/tb_bounded_fifo_window_mean.sv =====
// top of the testbench: clock, reset, command stimulus, watchdog and verdict
`timescale 1ns / 1ps
module tb_bounded_fifo_window_mean;
	import bfwm_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_CMDS = 1030;
	localparam int DRAIN_CYCLES = 30;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              action;
	logic [YEAR_W-1:0] year_in;
	logic              busy;
	logic              done;
	logic              status;
	logic              out_valid;
	logic [YEAR_W-1:0] year_out;
	logic [YEAR_W-1:0] mean_year;
	logic [OCC_W-1:0]  occupancy;

	int fail_count;
	int pending;
	int checked;
	int evictions;
	int empty_pops;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;

	bounded_fifo_window_mean uut (
		.clk, .arst_n, .start, .busy, .action, .year_in,
		.done, .status, .out_valid, .year_out, .mean_year, .occupancy
	);

	bfwm_checker watch (
		.clk, .arst_n, .start, .busy, .action, .year_in,
		.done, .status, .out_valid, .year_out, .mean_year, .occupancy,
		.fail_count, .pending, .checked, .evictions, .empty_pops
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// entered and left at a falling edge; busy only moves on rising edges
	task automatic issue(input logic act, input logic [YEAR_W-1:0] yr);
		int gap;
		bit took;
		gap = 0;
		if (!no_idle && $urandom_range(99) < 35)
			gap = $urandom_range(1, 30);
		if (gap > 0) begin
			start <= 1'b0;
			action <= 1'($urandom);
			year_in <= YEAR_W'($urandom);
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		year_in <= yr;
		do begin
			took = !busy;
			@(negedge clk);
		end while (!took);
	endtask

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int insert_pct;
		logic [YEAR_W-1:0] yr;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_INSERT;
		year_in = '0;
		insert_pct = 50;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty removes, extremes, rounding, eviction on full
		issue(ACT_REMOVE, 12'd0);
		issue(ACT_INSERT, 12'd0);
		issue(ACT_INSERT, 12'hfff);
		issue(ACT_REMOVE, 12'd0);
		issue(ACT_REMOVE, 12'd0);
		issue(ACT_REMOVE, 12'hfff);
		issue(ACT_INSERT, 12'd1);
		issue(ACT_INSERT, 12'd2);
		repeat (5) issue(ACT_INSERT, 12'hfff);
		issue(ACT_INSERT, 12'haaa);
		issue(ACT_INSERT, 12'h555);
		repeat (5) issue(ACT_REMOVE, 12'hfff);
		issue(ACT_REMOVE, 12'h555);
		issue(ACT_INSERT, 12'd7);

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			// shift the insert/remove mix so the queue spends time empty, mid and full
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 15;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			no_idle = (i >= 400 && i < 600);
			case ($urandom_range(9))
				0: yr = '0;
				1: yr = '1;
				2: yr = YEAR_W'($urandom_range(15));
				default: yr = YEAR_W'($urandom);
			endcase
			issue(($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE, yr);
		end
		start <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d command results, %0d of them evictions from a full queue",
			checked, evictions);
		$display("%0d removes hit an empty queue", empty_pops);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
